// File: hw/rtl/sfcbd_pkg.sv
// Shared types, constants and the ladder decode function for the status frame checker.
`default_nettype none
package sfcbd_pkg;

    localparam int unsigned WORD_W   = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned MASK_W   = 4;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned CODE_W   = 10;
    localparam int unsigned MV_W     = 14;
    localparam int unsigned PROD_W   = CODE_W + MV_W;
    localparam int unsigned RELOAD_W = 8;

    localparam logic [BYTE_W-1:0]   SUM_GOOD      = 8'hFF;
    localparam logic [WORD_W-1:0]   IDLE_LEVEL    = 16'd60;
    localparam logic [WORD_W-1:0]   ENTER_LEVEL   = 16'd1500;
    localparam logic [WORD_W-1:0]   ENTER_OFFSET  = 16'h07FF;
    localparam logic [WORD_W-1:0]   EXIT_LEVEL    = 16'd720;
    localparam logic [WORD_W-1:0]   LEFT_LEVEL    = 16'd270;
    localparam logic [MASK_W-1:0]   BTN_ENTER     = 4'h1;
    localparam logic [MASK_W-1:0]   BTN_RIGHT     = 4'h2;
    localparam logic [MASK_W-1:0]   BTN_LEFT      = 4'h4;
    localparam logic [MASK_W-1:0]   BTN_EXIT      = 4'h8;
    localparam logic [MV_W-1:0]     BATT_SCALE    = 14'd14180;
    localparam int unsigned         BATT_SHIFT    = 10;
    localparam logic [MV_W-1:0]     BATT_MV_MAX   = 14'd14166;
    localparam logic [RELOAD_W-1:0] RELOAD_RESET  = 8'(50 / 2);

    // Button state update request from the pipeline
    typedef struct packed {
        logic              en;
        logic [WORD_W-1:0] ladder;
    } btn_req_t;

    function automatic logic [MASK_W-1:0] decode_ladder(input logic [WORD_W-1:0] v);
        logic [MASK_W-1:0] mask;
        logic [WORD_W-1:0] rest;
        mask = '0;
        rest = v;
        if (v > ENTER_LEVEL) begin
            mask = mask | BTN_ENTER;
            rest = v - ENTER_OFFSET;
        end
        if (rest > EXIT_LEVEL) begin
            mask = mask | BTN_EXIT;
        end else if (rest > LEFT_LEVEL) begin
            mask = mask | BTN_LEFT;
        end else if (rest > IDLE_LEVEL) begin
            mask = mask | BTN_RIGHT;
        end
        return mask;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sfcbd_frame_check.sv
// Byte-sum checksum of one 13-byte status frame.
`default_nettype none
module sfcbd_frame_check (
    input  wire logic [sfcbd_pkg::WORD_W-1:0] sensor_word_0,
    input  wire logic [sfcbd_pkg::WORD_W-1:0] sensor_word_1,
    input  wire logic [sfcbd_pkg::WORD_W-1:0] sensor_word_2,
    input  wire logic [sfcbd_pkg::WORD_W-1:0] sensor_word_3,
    input  wire logic [sfcbd_pkg::WORD_W-1:0] button_ladder,
    input  wire logic [sfcbd_pkg::WORD_W-1:0] extra_word,
    input  wire logic [sfcbd_pkg::BYTE_W-1:0] checksum,
    output logic                              frame_good
);
    import sfcbd_pkg::*;

    logic [BYTE_W-1:0] sum_a;
    logic [BYTE_W-1:0] sum_b;
    logic [BYTE_W-1:0] sum_c;
    logic [BYTE_W-1:0] sum_all;

    assign sum_a = sensor_word_0[15:8] + sensor_word_0[7:0]
                 + sensor_word_1[15:8] + sensor_word_1[7:0];
    assign sum_b = sensor_word_2[15:8] + sensor_word_2[7:0]
                 + sensor_word_3[15:8] + sensor_word_3[7:0];
    assign sum_c = button_ladder[15:8] + button_ladder[7:0]
                 + extra_word[15:8] + extra_word[7:0];
    assign sum_all = sum_a + sum_b + sum_c + checksum;

    assign frame_good = (sum_all == SUM_GOOD);

endmodule
`default_nettype wire

// File: hw/rtl/sfcbd_buttons.sv
// Ladder noise filter, decoder and debounce counter holding the button state.
`default_nettype none
module sfcbd_buttons (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire sfcbd_pkg::btn_req_t                 req,
    input  wire logic [sfcbd_pkg::RELOAD_W-1:0]      reload,
    output logic      [sfcbd_pkg::MASK_W-1:0]        held
);
    import sfcbd_pkg::*;

    logic [MASK_W-1:0]   held_reg,  held_next;
    logic [WORD_W-1:0]   prev_reg,  prev_next;
    logic [MASK_W-1:0]   cand_reg,  cand_next;
    logic [RELOAD_W-1:0] left_reg,  left_next;
    logic [MASK_W-1:0]   decoded;
    logic                active;

    assign decoded = decode_ladder(req.ladder);
    assign active  = req.en && ((req.ladder > IDLE_LEVEL) || (held_reg != '0));

    always_comb begin
        held_next = held_reg;
        prev_next = prev_reg;
        cand_next = cand_reg;
        left_next = left_reg;
        if (active) begin
            if (req.ladder != prev_reg) begin
                prev_next = req.ladder;
            end else if (decoded != cand_reg) begin
                cand_next = decoded;
                left_next = reload;
            end else if (left_reg != '0) begin
                left_next = left_reg - 1'b1;
            end else begin
                held_next = cand_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            prev_reg <= '0;
            cand_reg <= '0;
            left_reg <= RELOAD_RESET;
        end else begin
            held_reg <= held_next;
            prev_reg <= prev_next;
            cand_reg <= cand_next;
            left_reg <= left_next;
        end
    end

    assign held = held_reg;

endmodule
`default_nettype wire

// File: hw/rtl/status_frame_check_button_debounce.sv
// Top level: status frame checker with button debounce and battery readout.
//
// Usage: one status frame enters per s_valid/s_ready handshake on the s_
// ports. It lands in an input register; once the result register is empty
// or m_ready is high, the checksum, button update, battery scaling and frame
// counters are computed and written to the result register, which drives the
// m_ ports. Each item yields exactly one result: frame_good, the debounced
// button mask, battery millivolts from the last good frame, and the good and
// bad frame counts after this frame.
// Throughput: one item per cycle while m_ready holds high, set by the single
// compute stage between the input and result registers.
// Stall: while m_ready is low and a result waits, the input register still
// takes one more item; s_ready drops only when both registers are full.
// cfg_data loads the debounce reload value on a cfg_valid/cfg_ready
// handshake (cfg_ready is always high); write it only while idle.
// Reset (aresetn low, synchronous): pipeline empty, counters and button
// state cleared, debounce reload and counter back to 25.
`default_nettype none
module status_frame_check_button_debounce (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sfcbd_pkg::RELOAD_W-1:0]      cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [sfcbd_pkg::WORD_W-1:0]        s_sensor_word_0,
    input  wire logic [sfcbd_pkg::WORD_W-1:0]        s_sensor_word_1,
    input  wire logic [sfcbd_pkg::WORD_W-1:0]        s_sensor_word_2,
    input  wire logic [sfcbd_pkg::WORD_W-1:0]        s_sensor_word_3,
    input  wire logic [sfcbd_pkg::WORD_W-1:0]        s_button_ladder,
    input  wire logic [sfcbd_pkg::WORD_W-1:0]        s_extra_word,
    input  wire logic [sfcbd_pkg::BYTE_W-1:0]        s_checksum,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_frame_good,
    output logic      [sfcbd_pkg::MASK_W-1:0]        m_button_mask,
    output logic      [sfcbd_pkg::MV_W-1:0]          m_battery_millivolts,
    output logic      [sfcbd_pkg::COUNT_W-1:0]       m_good_frames,
    output logic      [sfcbd_pkg::COUNT_W-1:0]       m_bad_frames
);
    import sfcbd_pkg::*;

    logic                in_valid_reg;
    logic [WORD_W-1:0]   in_sw0_reg, in_sw1_reg, in_sw2_reg, in_sw3_reg;
    logic [WORD_W-1:0]   in_ladder_reg, in_extra_reg;
    logic [BYTE_W-1:0]   in_check_reg;

    logic                out_valid_reg;
    logic                out_good_reg;
    logic [MV_W-1:0]     out_mv_reg;
    logic [CODE_W-1:0]   code_reg,  code_next;
    logic [COUNT_W-1:0]  good_count_reg, bad_count_reg;
    logic [RELOAD_W-1:0] reload_reg;

    logic                advance;
    logic                frame_good;
    logic [PROD_W-1:0]   batt_prod;
    logic [MASK_W-1:0]   held;
    btn_req_t            btn_req;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    sfcbd_frame_check u_check (
        .sensor_word_0 (in_sw0_reg),
        .sensor_word_1 (in_sw1_reg),
        .sensor_word_2 (in_sw2_reg),
        .sensor_word_3 (in_sw3_reg),
        .button_ladder (in_ladder_reg),
        .extra_word    (in_extra_reg),
        .checksum      (in_check_reg),
        .frame_good    (frame_good)
    );

    assign btn_req.en     = advance && frame_good;
    assign btn_req.ladder = in_ladder_reg;

    sfcbd_buttons u_buttons (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (btn_req),
        .reload  (reload_reg),
        .held    (held)
    );

    assign code_next = frame_good ? in_extra_reg[CODE_W-1:0] : code_reg;
    assign batt_prod = PROD_W'(code_next) * PROD_W'(BATT_SCALE);

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sw0_reg    <= s_sensor_word_0;
            in_sw1_reg    <= s_sensor_word_1;
            in_sw2_reg    <= s_sensor_word_2;
            in_sw3_reg    <= s_sensor_word_3;
            in_ladder_reg <= s_button_ladder;
            in_extra_reg  <= s_extra_word;
            in_check_reg  <= s_checksum;
        end
    end

    // Result register and frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            out_good_reg   <= 1'b0;
            out_mv_reg     <= '0;
            code_reg       <= '0;
            good_count_reg <= '0;
            bad_count_reg  <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                out_good_reg  <= frame_good;
                out_mv_reg    <= batt_prod[PROD_W-1:BATT_SHIFT];
                code_reg      <= code_next;
                if (frame_good) begin
                    good_count_reg <= good_count_reg + 1'b1;
                end else begin
                    bad_count_reg <= bad_count_reg + 1'b1;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg <= RELOAD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            reload_reg <= cfg_data;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_frame_good         = out_good_reg;
    assign m_button_mask        = held;
    assign m_battery_millivolts = out_mv_reg;
    assign m_good_frames        = good_count_reg;
    assign m_bad_frames         = bad_count_reg;

    // Every item moved to the result register bumps exactly one counter
    a_one_count: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> COUNT_W'(good_count_reg + bad_count_reg)
                    == COUNT_W'($past(good_count_reg + bad_count_reg) + 1'b1))
        else $error("frame counters did not advance by one");

    // Bad frames leave buttons and battery untouched
    a_bad_frame_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !frame_good) |=> ($stable(held) && $stable(code_reg)))
        else $error("bad frame changed button or battery state");

    // Decoder gives at most one of right, left, exit
    a_mask_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(held[MASK_W-1:1]) <= 1)
        else $error("button mask holds more than one ladder button");

    a_mv_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_mv_reg <= BATT_MV_MAX)
        else $error("battery millivolts out of range");

    // Input side only blocks when both stages are full and output stalls
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

endmodule
`default_nettype wire
